// File: design/tmgs_pkg.sv
`timescale 1ns / 1ps

package tmgs_pkg;

    // Field widths
    localparam int SIZE_W  = 48;
    localparam int LEN_W   = 32;
    localparam int COUNT_W = 32;
    localparam int SLOTS_W = 8;
    localparam int CD_W    = 40;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;

    // Action codes
    localparam logic ACT_REPORT = 1'b0;
    localparam logic ACT_TICK   = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SIZE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GROW_STEP     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHRINK_STEP   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_SLOTS = 2'd3;

    // Register reset values
    localparam logic [SIZE_W-1:0]  MAX_SIZE_RST      = 48'd0;
    localparam logic [SIZE_W-1:0]  GROW_STEP_RST     = 48'd268435456;
    localparam logic [SIZE_W-1:0]  SHRINK_STEP_RST   = 48'd67108864;
    localparam logic [SLOTS_W-1:0] BACKOFF_SLOTS_RST = 8'd100;

    typedef struct packed {
        logic               action;
        logic [SIZE_W-1:0]  slot_start;
        logic [LEN_W-1:0]   slot_length;
        logic [COUNT_W-1:0] trigger_level;
        logic [COUNT_W-1:0] event_count;
        logic [SIZE_W-1:0]  current_size;
    } item_t;

    typedef struct packed {
        logic              request_valid;
        logic              request_grow;
        logic [SIZE_W-1:0] req_size;
    } result_t;

    // Size request from one of the policy units
    typedef struct packed {
        logic              valid;
        logic [SIZE_W-1:0] size;
    } size_req_t;

endpackage

// File: design/tmgs_item_if.sv
`timescale 1ns / 1ps

interface tmgs_item_if;
    import tmgs_pkg::*;

    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: design/tmgs_result_if.sv
`timescale 1ns / 1ps

interface tmgs_result_if;
    import tmgs_pkg::*;

    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: design/threshold_memory_grow_shrink_policy.sv
`timescale 1ns / 1ps

// Channel  | Dir | Handshake     | Word
// ---------+-----+---------------+---------------------------------------------
// item     | in  | valid/ready   | action, slot_start, slot_length,
//          |     |               | trigger_level, event_count, current_size
// result   | out | valid/ready   | request_valid, request_grow, req_size
// cfg      | in  | cfg_wr_en     | cfg_index, cfg_data (write only)
//
// Every accepted word gives exactly one result word, via the input register
// and then the result register. One word per cycle is sustained while result
// is ready; the two registers pass words on in the same cycle. When result is
// stalled, the input register holds one more word, then item.ready drops.
// rst_n clears all control and policy state at once.
module threshold_memory_grow_shrink_policy
(
    input  logic                               clk,
    input  logic                               rst_n,
    tmgs_item_if.sink                          item,
    tmgs_result_if.source                      result,
    input  logic                               cfg_wr_en,
    input  logic [tmgs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tmgs_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import tmgs_pkg::*;

    // Configuration registers
    logic [SIZE_W-1:0]  max_size_reg;
    logic [SIZE_W-1:0]  grow_step_reg;
    logic [SIZE_W-1:0]  shrink_step_reg;
    logic [SLOTS_W-1:0] backoff_slots_reg;

    // Input stage and result stage
    item_t   item_reg;
    logic    item_valid_reg;
    result_t out_reg, out_next;
    logic    out_valid_reg;

    logic      advance;
    logic      report_en;
    logic      tick_en;
    size_req_t grow_req;
    size_req_t shrink_req;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_size_reg      <= MAX_SIZE_RST;
            grow_step_reg     <= GROW_STEP_RST;
            shrink_step_reg   <= SHRINK_STEP_RST;
            backoff_slots_reg <= BACKOFF_SLOTS_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_MAX_SIZE:      max_size_reg      <= cfg_data[SIZE_W-1:0];
                REG_GROW_STEP:     grow_step_reg     <= cfg_data[SIZE_W-1:0];
                REG_SHRINK_STEP:   shrink_step_reg   <= cfg_data[SIZE_W-1:0];
                REG_BACKOFF_SLOTS: backoff_slots_reg <= cfg_data[SLOTS_W-1:0];
                default:           ;
            endcase
        end
    end

    // Pipeline flow
    assign advance    = item_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !item_valid_reg || advance;
    assign report_en  = advance && (item_reg.action == ACT_REPORT);
    assign tick_en    = advance && (item_reg.action == ACT_TICK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            item_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            item_reg <= item.data;
        end
    end

    tmgs_slot u_slot
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .report_en     (report_en),
        .slot_start    (item_reg.slot_start),
        .slot_length   (item_reg.slot_length),
        .trigger_level (item_reg.trigger_level),
        .event_count   (item_reg.event_count),
        .current_size  (item_reg.current_size),
        .max_size      (max_size_reg),
        .grow_step     (grow_step_reg),
        .grow_req      (grow_req)
    );

    tmgs_backoff u_backoff
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .report_en     (report_en),
        .tick_en       (tick_en),
        .slot_length   (item_reg.slot_length),
        .current_size  (item_reg.current_size),
        .shrink_step   (shrink_step_reg),
        .backoff_slots (backoff_slots_reg),
        .shrink_req    (shrink_req)
    );

    // Pick the request of the unit that handled this word
    always_comb
    begin
        if (item_reg.action == ACT_REPORT)
        begin
            out_next.request_valid = grow_req.valid;
            out_next.request_grow  = grow_req.valid;
            out_next.req_size      = grow_req.size;
        end
        else
        begin
            out_next.request_valid = shrink_req.valid;
            out_next.request_grow  = 1'b0;
            out_next.req_size      = shrink_req.size;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || result.ready)
        begin
            out_valid_reg <= item_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

endmodule

// File: design/tmgs_slot.sv
`timescale 1ns / 1ps

// Slot tracking and grow decision for counter reports
module tmgs_slot
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             report_en,
    input  logic [tmgs_pkg::SIZE_W-1:0]      slot_start,
    input  logic [tmgs_pkg::LEN_W-1:0]       slot_length,
    input  logic [tmgs_pkg::COUNT_W-1:0]     trigger_level,
    input  logic [tmgs_pkg::COUNT_W-1:0]     event_count,
    input  logic [tmgs_pkg::SIZE_W-1:0]      current_size,
    input  logic [tmgs_pkg::SIZE_W-1:0]      max_size,
    input  logic [tmgs_pkg::SIZE_W-1:0]      grow_step,
    output tmgs_pkg::size_req_t              grow_req
);
    import tmgs_pkg::*;

    logic [SIZE_W-1:0] open_start_reg, open_start_next;
    logic [SIZE_W-1:0] total_reg, total_next;

    logic [SIZE_W-1:0] lower;
    logic [SIZE_W:0]   acc_sum;
    logic [SIZE_W-1:0] acc_sat;
    logic [SIZE_W-1:0] total_upd;
    logic [SIZE_W-1:0] open_upd;
    logic [SIZE_W:0]   grow_sum;

    // Slot rule and running total
    always_comb
    begin
        lower   = slot_start - {{(SIZE_W-LEN_W){1'b0}}, slot_length};
        acc_sum = {1'b0, total_reg} + {{(SIZE_W+1-COUNT_W){1'b0}}, event_count};
        acc_sat = acc_sum[SIZE_W] ? {SIZE_W{1'b1}} : acc_sum[SIZE_W-1:0];
        if (open_start_reg == '0)
        begin
            open_upd  = slot_start;
            total_upd = {{(SIZE_W-COUNT_W){1'b0}}, event_count};
        end
        else if (open_start_reg <= slot_start || open_start_reg < lower)
        begin
            open_upd  = open_start_reg;
            total_upd = acc_sat;
        end
        else
        begin
            open_upd  = slot_start;
            total_upd = {{(SIZE_W-COUNT_W){1'b0}}, event_count};
        end
    end

    // Threshold check and capped grow size
    always_comb
    begin
        grow_sum        = {1'b0, current_size} + {1'b0, grow_step};
        open_start_next = open_upd;
        total_next      = total_upd;
        grow_req.valid  = 1'b0;
        grow_req.size   = '0;
        if (total_upd > {{(SIZE_W-COUNT_W){1'b0}}, trigger_level})
        begin
            open_start_next = '0;
            total_next      = '0;
            if (current_size != max_size)
            begin
                grow_req.valid = 1'b1;
                grow_req.size  = (grow_sum <= {1'b0, max_size}) ?
                                 grow_sum[SIZE_W-1:0] : max_size;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_start_reg <= '0;
            total_reg      <= '0;
        end
        else if (report_en)
        begin
            open_start_reg <= open_start_next;
            total_reg      <= total_next;
        end
    end

endmodule

// File: design/tmgs_backoff.sv
`timescale 1ns / 1ps

// Backoff countdown and shrink decision
module tmgs_backoff
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             report_en,
    input  logic                             tick_en,
    input  logic [tmgs_pkg::LEN_W-1:0]       slot_length,
    input  logic [tmgs_pkg::SIZE_W-1:0]      current_size,
    input  logic [tmgs_pkg::SIZE_W-1:0]      shrink_step,
    input  logic [tmgs_pkg::SLOTS_W-1:0]     backoff_slots,
    output tmgs_pkg::size_req_t              shrink_req
);
    import tmgs_pkg::*;

    logic [LEN_W-1:0] last_len_reg;
    logic [CD_W-1:0]  countdown_reg, countdown_next;
    logic             armed_reg, armed_next;

    logic [LEN_W-1:0] load_len;
    logic [CD_W-1:0]  load_val;
    logic [CD_W-1:0]  dec_val;

    // One 8x32 multiplier serves both the report load and the rearm
    assign load_len = report_en ? slot_length : last_len_reg;
    assign load_val = {{(CD_W-LEN_W){1'b0}}, load_len} * {{(CD_W-SLOTS_W){1'b0}}, backoff_slots};
    assign dec_val  = (countdown_reg != '0) ? countdown_reg - 1'b1 : countdown_reg;

    always_comb
    begin
        countdown_next   = countdown_reg;
        armed_next       = armed_reg;
        shrink_req.valid = 1'b0;
        shrink_req.size  = '0;
        if (report_en)
        begin
            countdown_next = load_val;
            armed_next     = 1'b1;
        end
        else if (tick_en && armed_reg)
        begin
            countdown_next = dec_val;
            if (dec_val == '0)
            begin
                armed_next = 1'b0;
                if (current_size != '0)
                begin
                    shrink_req.valid = 1'b1;
                    shrink_req.size  = (current_size < shrink_step) ?
                                       '0 : current_size - shrink_step;
                    countdown_next   = load_val;
                    armed_next       = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_len_reg  <= '0;
            countdown_reg <= '0;
            armed_reg     <= 1'b0;
        end
        else
        begin
            if (report_en)
            begin
                last_len_reg <= slot_length;
            end
            countdown_reg <= countdown_next;
            armed_reg     <= armed_next;
        end
    end

endmodule
